>>> rtl/eat_pkg.sv
`default_nettype none

package eat_pkg;

  // expert table geometry
  localparam int unsigned NumExperts = 16;
  localparam int unsigned ExpW       = $clog2(NumExperts);
  localparam int unsigned TotW       = $clog2(NumExperts + 1);
  localparam int unsigned Phases     = 3;
  localparam int unsigned CntW       = 32;
  localparam int unsigned RowW       = Phases * CntW;

  // field widths
  localparam int unsigned LayerW  = 8;
  localparam int unsigned PosW    = 32;
  localparam int unsigned TokW    = 16;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned EpochW  = 32;
  localparam int unsigned EcW     = 5;
  localparam int unsigned PromptW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 31;

  // request kinds
  localparam logic KindBegin  = 1'b0;
  localparam logic KindSelect = 1'b1;

  // phase codes
  localparam logic [1:0] PhaseUnknown = 2'd0;
  localparam logic [1:0] PhasePrefill = 2'd1;
  localparam logic [1:0] PhaseDecode  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegExpertCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRequestActive = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPromptLength  = 2'd2;

  localparam logic [EcW-1:0] ExpertCountReset = EcW'(NumExperts);

  typedef enum logic [2:0] {
    StIdle,
    StUpdate,
    StListRd,
    StRowRd,
    StEmit
  } eat_state_e;

endpackage

`default_nettype wire

>>> rtl/eat_chan_if.sv
`default_nettype none

interface eat_req_if;
  import eat_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [LayerW-1:0]        layer_id;
  logic signed [PosW-1:0]   first_position;
  logic signed [TokW-1:0]   batch_tokens;
  logic signed [IdxW-1:0]   expert_index;
  logic                     token_done;

  modport source (
    output valid, kind, layer_id, first_position, batch_tokens, expert_index, token_done,
    input  ready
  );
  modport sink (
    input  valid, kind, layer_id, first_position, batch_tokens, expert_index, token_done,
    output ready
  );
endinterface

interface eat_smp_if;
  import eat_pkg::*;
  logic                valid;
  logic                ready;
  logic [LayerW-1:0]   sample_layer;
  logic [3:0]          sample_expert;
  logic [1:0]          sample_phase;
  logic [CntW-1:0]     multiplicity;
  logic [EpochW-1:0]   sample_epoch;
  logic                last_sample;

  modport source (
    output valid, sample_layer, sample_expert, sample_phase, multiplicity, sample_epoch,
    output last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_layer, sample_expert, sample_phase, multiplicity, sample_epoch,
    input  last_sample,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/expert_activation_tally_top.sv
`default_nettype none

// Per-batch tally of routed expert selections, split into unknown, prefill and decode
// phases. Counts live in a synchronous memory with separate read and write ports, one row
// per expert (all three phase counts side by side), and the first-touch order lives in a
// small list memory.
// A select request reads its row while idle, then does the saturating increment and
// write-back in the update state; a begin, out-of-range or ignored select needs no update
// state. The select that closes a batch with any counts starts the publish walk, which
// steps through list read, row read and emit for each touched expert, emitting one sample
// per nonzero phase and waiting when the sample sink stalls; no request is taken during the
// walk. Row valid flops clear the whole count memory at once at reset, at begin and after
// publish, so there is no clearing pass. The sample output is registered and may still hold
// the last sample while the next request is taken.
module expert_activation_tally_top import eat_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgW-1:0]      cfg_wdata_i,
  eat_req_if.sink             req_i,
  eat_smp_if.source           smp_o
);

  eat_state_e state_q, state_d;

  logic [EcW-1:0]       expert_count_q;
  logic                 req_active_q;
  logic [PromptW-1:0]   prompt_len_q;

  logic                 batch_valid_q;
  logic [TokW-1:0]      item_idx_q;
  logic [PosW-2:0]      base_pos_q;
  logic [TokW-1:0]      batch_len_q;
  logic [LayerW-1:0]    layer_q;
  logic [EpochW-1:0]    epoch_src_q;
  logic [EpochW-1:0]    epoch_q;

  logic [TotW-1:0]       touched_total_q;
  logic [NumExperts-1:0] row_valid_q;

  logic [ExpW-1:0]      sel_idx_q;
  logic [1:0]           sel_phase_q;
  logic                 sel_done_q;

  logic [ExpW-1:0]      ptr_q;
  logic [Phases-1:0]    pend_q;

  // count and touched-list memories
  logic [RowW-1:0]      cnt_mem [NumExperts];
  logic [ExpW-1:0]      tl_mem  [NumExperts];
  logic [RowW-1:0]      rd_row_q;
  logic                 rd_vld_q;
  logic [ExpW-1:0]      tl_rd_q;
  logic [ExpW-1:0]      cnt_raddr;

  logic                 out_valid_q;
  logic [LayerW-1:0]    out_layer_q;
  logic [3:0]           out_expert_q;
  logic [1:0]           out_phase_q;
  logic [CntW-1:0]      out_mult_q;
  logic [EpochW-1:0]    out_epoch_q;
  logic                 out_last_q;

  logic                 req_fire;
  logic [EcW-1:0]       limit;
  logic                 sel_live;
  logic                 in_range;
  logic [PosW-1:0]      pos_now;
  logic [1:0]           phase_now;
  logic                 begin_valid;
  logic [TokW-1:0]      item_next;
  logic                 batch_end;
  logic [RowW-1:0]      row_data;
  logic [RowW-1:0]      row_upd;
  logic [CntW-1:0]      cnt_old;
  logic [CntW-1:0]      cnt_inc;
  logic [Phases-1:0]    nz;
  logic [Phases-1:0]    eff;
  logic [Phases-1:0]    pick;
  logic [Phases-1:0]    rest;
  logic [1:0]           pick_ph;
  logic [CntW-1:0]      pick_cnt;
  logic                 last_ptr;
  logic                 slot_free;
  logic [TotW-1:0]      tot_next;

  logic begin_go, sel_go, upd_go, wr_en, append, adv, finish, pub_empty;
  logic load, advance_row, pub_end, wipe;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  assign limit     = (expert_count_q > EcW'(NumExperts)) ? EcW'(NumExperts) : expert_count_q;
  assign sel_live  = batch_valid_q && (limit != '0);
  assign in_range  = !req_i.expert_index[IdxW-1] &&
                     (req_i.expert_index[IdxW-2:0] < (IdxW-1)'(limit));

  assign pos_now = {1'b0, base_pos_q} + PosW'(item_idx_q);
  always_comb begin
    if (req_active_q) begin
      phase_now = (pos_now < PosW'(prompt_len_q)) ? PhasePrefill : PhaseDecode;
    end else begin
      phase_now = (batch_len_q > TokW'(1)) ? PhasePrefill : PhaseUnknown;
    end
  end

  assign begin_valid = !req_i.first_position[PosW-1] && !req_i.batch_tokens[TokW-1] &&
                       (req_i.batch_tokens != '0);

  assign item_next = item_idx_q + TokW'(1);
  assign batch_end = (item_next >= batch_len_q);

  // unwritten rows read as zero
  assign row_data = rd_vld_q ? rd_row_q : '0;
  assign cnt_old  = row_data[sel_phase_q*CntW +: CntW];
  assign cnt_inc  = (&cnt_old) ? cnt_old : cnt_old + CntW'(1);

  always_comb begin
    row_upd = row_data;
    row_upd[sel_phase_q*CntW +: CntW] = cnt_inc;
  end

  always_comb begin
    for (int p = 0; p < Phases; p++) begin
      nz[p] = |row_data[p*CntW +: CntW];
    end
  end

  assign eff  = pend_q & nz;
  assign pick = eff & (~eff + Phases'(1));
  assign rest = eff & ~pick;

  always_comb begin
    pick_cnt = '0;
    for (int p = 0; p < Phases; p++) begin
      if (pick[p]) begin
        pick_cnt = row_data[p*CntW +: CntW];
      end
    end
  end

  always_comb begin
    priority if (eff[0]) begin
      pick_ph = PhaseUnknown;
    end else if (eff[1]) begin
      pick_ph = PhasePrefill;
    end else begin
      pick_ph = PhaseDecode;
    end
  end

  assign last_ptr  = ({1'b0, ptr_q} == (touched_total_q - TotW'(1)));
  assign slot_free = !out_valid_q || smp_o.ready;

  // control strobes
  always_comb begin
    begin_go  = req_fire && (req_i.kind == KindBegin);
    sel_go    = req_fire && (req_i.kind == KindSelect) && sel_live;
    upd_go    = sel_go && in_range;
    wr_en     = (state_q == StUpdate);
    append    = wr_en && !(|row_data) && (touched_total_q < TotW'(NumExperts));
    tot_next  = touched_total_q + TotW'(append);
    adv       = (sel_go && !in_range && req_i.token_done) || (wr_en && sel_done_q);
    finish    = adv && batch_end;
    pub_empty = (tot_next == '0);
    load      = (state_q == StEmit) && slot_free && (eff != '0);
    advance_row = (state_q == StEmit) && ((eff == '0) || (slot_free && (rest == '0)));
    pub_end   = advance_row && last_ptr;
    wipe      = begin_go || pub_end;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (upd_go) begin
          state_d = StUpdate;
        end else if (finish && !pub_empty) begin
          state_d = StListRd;
        end
      end
      StUpdate: begin
        state_d = (finish && !pub_empty) ? StListRd : StIdle;
      end
      StListRd: state_d = StRowRd;
      StRowRd:  state_d = StEmit;
      StEmit: begin
        if (advance_row) begin
          state_d = pub_end ? StIdle : StListRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign cnt_raddr = (state_q == StIdle) ? req_i.expert_index[ExpW-1:0] : tl_rd_q;

  always_ff @(posedge clk_i) begin
    rd_row_q <= cnt_mem[cnt_raddr];
    rd_vld_q <= row_valid_q[cnt_raddr];
    tl_rd_q  <= tl_mem[ptr_q];
    if (wr_en) begin
      cnt_mem[sel_idx_q] <= row_upd;
    end
    if (append) begin
      tl_mem[touched_total_q[ExpW-1:0]] <= sel_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      expert_count_q  <= ExpertCountReset;
      req_active_q    <= 1'b0;
      prompt_len_q    <= '0;
      batch_valid_q   <= 1'b0;
      item_idx_q      <= '0;
      base_pos_q      <= '0;
      batch_len_q     <= '0;
      layer_q         <= '0;
      epoch_src_q     <= EpochW'(1);
      epoch_q         <= '0;
      touched_total_q <= '0;
      row_valid_q     <= '0;
      ptr_q           <= '0;
      pend_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegExpertCount:   expert_count_q <= cfg_wdata_i[EcW-1:0];
          RegRequestActive: req_active_q   <= cfg_wdata_i[0];
          RegPromptLength:  prompt_len_q   <= cfg_wdata_i[PromptW-1:0];
          default: ;
        endcase
      end

      if (begin_go) begin
        batch_valid_q <= begin_valid;
        item_idx_q    <= '0;
        base_pos_q    <= req_i.first_position[PosW-2:0];
        batch_len_q   <= req_i.batch_tokens;
        layer_q       <= req_i.layer_id;
        // zero is never handed out as an epoch
        if (epoch_src_q == '0) begin
          epoch_q     <= EpochW'(1);
          epoch_src_q <= EpochW'(2);
        end else begin
          epoch_q     <= epoch_src_q;
          epoch_src_q <= epoch_src_q + EpochW'(1);
        end
      end else begin
        if (adv) begin
          item_idx_q <= item_next;
        end
        if (finish) begin
          batch_valid_q <= 1'b0;
        end
      end

      if (wipe) begin
        row_valid_q     <= '0;
        touched_total_q <= '0;
      end else begin
        if (wr_en) begin
          row_valid_q[sel_idx_q] <= 1'b1;
        end
        touched_total_q <= tot_next;
      end

      if (finish) begin
        ptr_q <= '0;
      end else if (advance_row && !pub_end) begin
        ptr_q <= ptr_q + ExpW'(1);
      end

      if (state_q == StRowRd) begin
        pend_q <= '1;
      end else if (load) begin
        pend_q <= pend_q & ~pick;
      end

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (smp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // select context and sample payload
  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      sel_idx_q   <= req_i.expert_index[ExpW-1:0];
      sel_phase_q <= phase_now;
      sel_done_q  <= req_i.token_done;
    end
    if (load) begin
      out_layer_q  <= layer_q;
      out_expert_q <= 4'(tl_rd_q);
      out_phase_q  <= pick_ph;
      out_mult_q   <= pick_cnt;
      out_epoch_q  <= epoch_q;
      out_last_q   <= last_ptr && (rest == '0);
    end
  end

  assign smp_o.valid         = out_valid_q;
  assign smp_o.sample_layer  = out_layer_q;
  assign smp_o.sample_expert = out_expert_q;
  assign smp_o.sample_phase  = out_phase_q;
  assign smp_o.multiplicity  = out_mult_q;
  assign smp_o.sample_epoch  = out_epoch_q;
  assign smp_o.last_sample   = out_last_q;

endmodule

`default_nettype wire

>>> rtl/eat_checker.sv
`default_nettype none

module eat_checker import eat_pkg::*; (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               req_ready_i,
  input wire               smp_valid_i,
  input wire               smp_ready_i,
  input wire [LayerW-1:0]  smp_layer_i,
  input wire [3:0]         smp_expert_i,
  input wire [1:0]         smp_phase_i,
  input wire [CntW-1:0]    smp_mult_i,
  input wire [EpochW-1:0]  smp_epoch_i,
  input wire               smp_last_i
);

  // only the three phase codes are ever published
  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i |-> (smp_phase_i == PhaseUnknown || smp_phase_i == PhasePrefill ||
                     smp_phase_i == PhaseDecode))
    else $error("sample phase out of range");

  // a published count and its epoch are never zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i |-> (smp_mult_i != '0) && (smp_epoch_i != '0))
    else $error("zero multiplicity or epoch");

  // a new request is only taken once the batch's final sample is out
  a_no_req_mid_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i |-> !(smp_valid_i && !smp_last_i))
    else $error("request taken while publish incomplete");

  a_smp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |=> smp_valid_i && $stable(smp_layer_i) &&
      $stable(smp_expert_i) && $stable(smp_phase_i) && $stable(smp_mult_i) &&
      $stable(smp_epoch_i) && $stable(smp_last_i))
    else $error("stalled sample changed");

endmodule

bind expert_activation_tally_top eat_checker u_eat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .smp_valid_i  (smp_o.valid),
  .smp_ready_i  (smp_o.ready),
  .smp_layer_i  (smp_o.sample_layer),
  .smp_expert_i (smp_o.sample_expert),
  .smp_phase_i  (smp_o.sample_phase),
  .smp_mult_i   (smp_o.multiplicity),
  .smp_epoch_i  (smp_o.sample_epoch),
  .smp_last_i   (smp_o.last_sample)
);

`default_nettype wire

>>> verif/expert_activation_tally_checker.sv
`timescale 1ns / 100ps

module expert_activation_tally_checker import eat_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire [CfgIdxW-1:0] cfg_idx_i,
  input  wire [CfgW-1:0]    cfg_wdata_i,
  eat_req_if                req_mon,
  eat_smp_if                smp_mon,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [LayerW-1:0] layer;
    logic [ExpW-1:0]   expert;
    logic [1:0]        phase;
    logic [CntW-1:0]   mult;
    logic [EpochW-1:0] epoch;
    logic              last;
  } tally_sample_t;

  logic [CntW-1:0]    tally_cnt [Phases][NumExperts];
  logic [ExpW-1:0]    touch_order [NumExperts];
  int unsigned        touch_total;
  logic               batch_open;
  logic [TokW-1:0]    token_pos;
  logic [PosW-1:0]    base_pos;
  logic [TokW-1:0]    batch_len;
  logic [LayerW-1:0]  batch_layer;
  logic [EpochW-1:0]  epoch_next;
  logic [EpochW-1:0]  epoch_cur;
  logic [EcW-1:0]     expert_limit;
  logic               prompt_known;
  logic [PromptW-1:0] prompt_len;
  tally_sample_t      tally_q[$];
  tally_sample_t      got;
  tally_sample_t      want;

  function automatic void clear_touched();
    for (int i = 0; i < touch_total; i++) begin
      for (int p = 0; p < Phases; p++) tally_cnt[p][touch_order[i]] = '0;
    end
    touch_total = 0;
  endfunction

  // predicts the effect of one accepted request, queuing any published tallies
  task automatic tally_request();
    int unsigned     lim;
    logic [IdxW-1:0] idx;
    logic [ExpW-1:0] e;
    logic [1:0]      ph;
    longint          pos;
    bit              seen;
    bit              held;
    tally_sample_t   s;
    held = 0;
    s = '0;
    if (req_mon.kind == KindBegin) begin
      clear_touched();
      batch_open = !req_mon.first_position[PosW-1] && !req_mon.batch_tokens[TokW-1] &&
                   (req_mon.batch_tokens != 0);
      batch_layer = req_mon.layer_id;
      base_pos = req_mon.first_position;
      token_pos = '0;
      batch_len = req_mon.batch_tokens;
      epoch_cur = epoch_next;
      epoch_next = epoch_next + 1'b1;
      // zero is never handed out as an epoch
      if (epoch_cur == '0) begin
        epoch_cur = epoch_next;
        epoch_next = epoch_next + 1'b1;
      end
    end else begin
      lim = (expert_limit > NumExperts) ? NumExperts : expert_limit;
      if (batch_open && lim != 0) begin
        idx = req_mon.expert_index;
        if (!idx[IdxW-1] && idx < lim) begin
          e = idx[ExpW-1:0];
          if (prompt_known) begin
            pos = longint'($signed(base_pos)) + longint'(token_pos);
            ph = (pos < longint'(prompt_len)) ? PhasePrefill : PhaseDecode;
          end else begin
            ph = (batch_len > 1) ? PhasePrefill : PhaseUnknown;
          end
          seen = 0;
          for (int p = 0; p < Phases; p++) if (tally_cnt[p][e] != '0) seen = 1;
          if (!seen && touch_total < NumExperts) begin
            touch_order[touch_total] = e;
            touch_total++;
          end
          if (tally_cnt[ph][e] != '1) tally_cnt[ph][e] = tally_cnt[ph][e] + 1'b1;
        end
        if (req_mon.token_done) begin
          token_pos = token_pos + 1'b1;
          if (token_pos >= batch_len) begin
            batch_open = 0;
            // hold one tally back so the final one can carry the last flag
            for (int i = 0; i < touch_total; i++) begin
              for (int p = 0; p < Phases; p++) begin
                if (tally_cnt[p][touch_order[i]] != '0) begin
                  if (held) tally_q.push_back(s);
                  s.layer = batch_layer;
                  s.expert = touch_order[i];
                  s.phase = p[1:0];
                  s.mult = tally_cnt[p][touch_order[i]];
                  s.epoch = epoch_cur;
                  s.last = 1'b0;
                  held = 1;
                end
              end
            end
            if (held) begin
              s.last = 1'b1;
              tally_q.push_back(s);
            end
            clear_touched();
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < Phases; p++) begin
        for (int e = 0; e < NumExperts; e++) tally_cnt[p][e] = '0;
      end
      for (int i = 0; i < NumExperts; i++) touch_order[i] = '0;
      touch_total = 0;
      batch_open = 0;
      token_pos = '0;
      base_pos = '0;
      batch_len = '0;
      batch_layer = '0;
      epoch_next = 1;
      epoch_cur = '0;
      expert_limit = ExpertCountReset;
      prompt_known = 0;
      prompt_len = '0;
      tally_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegExpertCount:   expert_limit = cfg_wdata_i[EcW-1:0];
          RegRequestActive: prompt_known = cfg_wdata_i[0];
          RegPromptLength:  prompt_len = cfg_wdata_i[PromptW-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) tally_request();
      if (smp_mon.valid && smp_mon.ready) begin
        got.layer = smp_mon.sample_layer;
        got.expert = smp_mon.sample_expert;
        got.phase = smp_mon.sample_phase;
        got.mult = smp_mon.multiplicity;
        got.epoch = smp_mon.sample_epoch;
        got.last = smp_mon.last_sample;
        if (tally_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected tally layer %0d expert %0d phase %0d count %0d epoch %0d",
                     $realtime, got.layer, got.expert, got.phase, got.mult, got.epoch);
        end else begin
          want = tally_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: tally mismatch", $realtime);
              $display("  exp layer %0d expert %0d phase %0d count %0d epoch %0d last %0b",
                       want.layer, want.expert, want.phase, want.mult, want.epoch, want.last);
              $display("  got layer %0d expert %0d phase %0d count %0d epoch %0d last %0b",
                       got.layer, got.expert, got.phase, got.mult, got.epoch, got.last);
            end
          end
        end
      end
      pending_o = tally_q.size();
    end
  end

endmodule

>>> verif/expert_activation_tally_top_test.sv
`timescale 1ns / 100ps

module expert_activation_tally_top_test;
  import eat_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    int unsigned ec;
    bit          ra;
    int unsigned pl;
    int          budget;
  } reg_plan_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  int                 fail_count;
  int                 outstanding;
  int                 hold_asks = 0;
  int                 hold_done = 0;
  int                 burst_left = 0;
  int unsigned        cycle_count = 0;
  int unsigned        cur_ec;
  int unsigned        cur_pl;
  reg_plan_t          plan [8];

  eat_req_if req ();
  eat_smp_if smp ();

  expert_activation_tally_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .smp_o       (smp)
  );

  expert_activation_tally_checker tally_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_mon     (req),
    .smp_mon     (smp),
    .errors_o    (fail_count),
    .pending_o   (outstanding)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("expert_activation_tally_top_test: errors");
      $finish;
    end
  end

  // sample sink: random stall modes, plus one long hold-off on demand
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    smp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        smp.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (mode)
          0: smp.ready <= 1'b1;
          1: smp.ready <= 1'($urandom_range(0, 1));
          2: smp.ready <= ($urandom_range(0, 3) == 0);
          default: smp.ready <= (tick % 5 != 4);
        endcase
      end
    end
  end

  task automatic send_req(input logic kind, input logic [LayerW-1:0] layer,
                          input logic [PosW-1:0] pos, input logic [TokW-1:0] tok,
                          input logic [IdxW-1:0] idx, input logic done);
    int unsigned gap;
    int unsigned r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      gap = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 15);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.kind <= kind;
    req.layer_id <= layer;
    req.first_position <= pos;
    req.batch_tokens <= tok;
    req.expert_index <= idx;
    req.token_done <= done;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send_begin(input logic [LayerW-1:0] layer, input logic [PosW-1:0] pos,
                            input logic [TokW-1:0] tok);
    send_req(KindBegin, layer, pos, tok, IdxW'($urandom_range(0, 511)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic send_select(input logic [IdxW-1:0] idx, input logic done);
    send_req(KindSelect, LayerW'($urandom_range(0, 255)), $urandom(),
             TokW'($urandom_range(0, 65535)), idx, done);
  endtask

  task automatic set_regs(input int unsigned ec, input bit ra, input int unsigned pl);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegExpertCount;
    cfg_wdata_i <= CfgW'(ec);
    @(posedge clk_i);
    cfg_idx_i <= RegRequestActive;
    cfg_wdata_i <= CfgW'(ra);
    @(posedge clk_i);
    cfg_idx_i <= RegPromptLength;
    cfg_wdata_i <= CfgW'(pl);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_ec = ec;
    cur_pl = pl;
  endtask

  // stop sending and let every pending tally drain before touching registers
  task automatic idle_pause();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (10) @(posedge clk_i);
  endtask

  // one routed batch with random content, now and then cut short
  task automatic run_batch(input int unsigned lim, output int items);
    int unsigned tok;
    int unsigned picks;
    int unsigned r;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] raw;
    logic [IdxW-1:0] idx;
    bit cut;
    items = 0;
    r = $urandom_range(0, 9);
    tok = (r < 6) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 8) : $urandom_range(9, 20);
    r = $urandom_range(0, 9);
    raw = $urandom();
    if (r < 5) pos = $urandom_range(0, 40);
    else if (r < 8) pos = (cur_pl >= tok) ? cur_pl - $urandom_range(0, tok) : $urandom_range(0, 3);
    else pos = {1'b0, raw[PosW-2:0]};
    send_begin(LayerW'($urandom_range(0, 255)), pos, tok[TokW-1:0]);
    items++;
    cut = ($urandom_range(0, 11) == 0);
    for (int t = 0; t < tok; t++) begin
      picks = $urandom_range(1, 4);
      for (int j = 0; j < picks; j++) begin
        if ($urandom_range(0, 19) < 17) idx = IdxW'($urandom_range(0, lim - 1));
        else idx = IdxW'($urandom_range(0, 511));
        send_select(idx, j == picks - 1);
        items++;
      end
      if (cut && t == tok / 2) return;
    end
  endtask

  // stray selects, invalid begins and oversized batches that get abandoned
  task automatic noise_items(output int items);
    int unsigned r;
    int unsigned n;
    logic [PosW-1:0] raw;
    logic [TokW-1:0] tok;
    items = 0;
    r = $urandom_range(0, 2);
    raw = $urandom();
    n = $urandom_range(1, 3);
    if (r == 0) begin
      send_select(IdxW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
      items++;
    end else begin
      if (r == 1) begin
        if ($urandom_range(0, 1)) begin
          send_begin(LayerW'($urandom_range(0, 255)), {1'b1, raw[PosW-2:0]},
                     TokW'($urandom_range(0, 65535)));
        end else begin
          tok = $urandom_range(0, 1) ? '0 : {1'b1, raw[TokW-2:0]};
          send_begin(LayerW'($urandom_range(0, 255)), $urandom_range(0, 100), tok);
        end
      end else begin
        tok = {1'b0, raw[TokW-2:0]};
        if (tok == '0) tok = 16'h7fff;
        send_begin(LayerW'($urandom_range(0, 255)), {1'b0, raw[PosW-1:1]}, tok);
      end
      items++;
      for (int i = 0; i < n; i++) begin
        send_select(IdxW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
        items++;
      end
    end
  endtask

  initial begin
    int items;
    int phase_items;
    int unsigned lim;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegExpertCount;
    cfg_wdata_i <= '0;
    req.valid <= 1'b0;
    req.kind <= KindBegin;
    req.layer_id <= '0;
    req.first_position <= '0;
    req.batch_tokens <= '0;
    req.expert_index <= '0;
    req.token_done <= 1'b0;
    plan[0] = '{16, 0, 0, 20};
    plan[1] = '{0, 1, 5, 4};
    plan[2] = '{31, 1, 32'h7fff_ffff, 4};
    plan[3] = '{1, 1, 0, 4};
    plan[4] = '{5, 1, 12, 4};
    plan[5] = '{16, 1, $urandom() & 32'h7fff_ffff, 4};
    plan[6] = '{9, 0, 0, 4};
    plan[7] = '{16, 0, 0, 4};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(16, 0, 0);

    // select before any batch is open
    send_select(9'd3, 1'b1);
    // single-token batch: unknown phase, extremes and out-of-range indices
    send_begin(8'd255, 32'd0, 16'd1);
    send_select(9'd0, 1'b0);
    send_select(9'd15, 1'b0);
    send_select(9'h1ff, 1'b0);
    send_select(9'h0ff, 1'b0);
    send_select(9'h100, 1'b0);
    send_select(9'd0, 1'b1);
    // invalid batches ignore their selects
    send_begin(8'd0, 32'h8000_0000, 16'd2);
    send_select(9'd1, 1'b1);
    send_begin(8'd1, 32'd0, 16'd0);
    send_begin(8'd2, 32'd0, 16'h8000);
    send_select(9'd2, 1'b1);
    // begin in the middle of a batch discards it
    send_begin(8'd7, 32'd5, 16'd3);
    send_select(9'd2, 1'b1);
    send_begin(8'd8, 32'h7fff_ffff, 16'h7fff);
    send_select(9'd4, 1'b0);
    // batch with nothing counted publishes nothing
    send_begin(8'd3, 32'd0, 16'd1);
    send_select(9'd16, 1'b1);
    // two-token prefill batch
    send_begin(8'd4, 32'd10, 16'd2);
    send_select(9'd5, 1'b0);
    send_select(9'd6, 1'b0);
    send_select(9'd5, 1'b1);
    send_select(9'd5, 1'b1);

    for (int pi = 0; pi < 8; pi++) begin
      idle_pause();
      set_regs(plan[pi].ec, plan[pi].ra, plan[pi].pl);
      lim = (cur_ec == 0 || cur_ec > NumExperts) ? NumExperts : cur_ec;
      phase_items = 0;
      while (phase_items < plan[pi].budget) begin
        // sink holds off while requests keep coming
        if (pi == 0 && hold_asks == 0) hold_asks++;
        if ($urandom_range(0, 9) < 8) run_batch(lim, items);
        else noise_items(items);
        phase_items += items;
      end
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("expert_activation_tally_top_test: clean");
    end else begin
      $display("expert_activation_tally_top_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/eat_pkg.sv
rtl/eat_chan_if.sv
rtl/expert_activation_tally_top.sv
rtl/eat_checker.sv
verif/expert_activation_tally_checker.sv
verif/expert_activation_tally_top_test.sv
